// ===== rtl/hrp_pkg.sv =====
// Shared types, character codes and helpers for the HTTP request head parser.
package hrp_pkg;

    localparam int ByteW    = 8;
    localparam int ClassW   = 3;
    localparam int VersionW = 2;
    localparam int InDataW  = 8;
    localparam int OutDataW = 16;
    localparam int OutUserW = 4;

    localparam logic [ByteW-1:0] ChCr    = 8'h0D;
    localparam logic [ByteW-1:0] ChLf    = 8'h0A;
    localparam logic [ByteW-1:0] ChSp    = 8'h20;
    localparam logic [ByteW-1:0] ChColon = 8'h3A;
    localparam logic [ByteW-1:0] ChSlash = 8'h2F;
    localparam logic [ByteW-1:0] ChZero  = 8'h30;
    localparam logic [ByteW-1:0] ChOne   = 8'h31;
    localparam logic [ByteW-1:0] ChTwo   = 8'h32;
    localparam logic [ByteW-1:0] ChUpA   = 8'h41;
    localparam logic [ByteW-1:0] ChUpZ   = 8'h5A;

    localparam logic [1:0] MethodLen = 2'd3;

    localparam logic [VersionW-1:0] Ver10      = 2'd0;
    localparam logic [VersionW-1:0] Ver11      = 2'd1;
    localparam logic [VersionW-1:0] Ver20      = 2'd2;
    localparam logic [VersionW-1:0] VerUnknown = 2'd3;

    localparam logic [1:0] MajorNone = 2'd0;
    localparam logic [1:0] MajorOne  = 2'd1;
    localparam logic [1:0] MajorTwo  = 2'd2;

    typedef enum logic [4:0] {
        PH_METHOD   = 5'd0,
        PH_SP1      = 5'd1,
        PH_URL      = 5'd2,
        PH_SP2      = 5'd3,
        PH_PROTO    = 5'd4,
        PH_MAJOR    = 5'd5,
        PH_DOT      = 5'd6,
        PH_MINOR    = 5'd7,
        PH_EOL      = 5'd8,
        PH_KEYFIRST = 5'd9,
        PH_KEY      = 5'd10,
        PH_COLSKIP  = 5'd11,
        PH_VSPFIRST = 5'd12,
        PH_VSPMORE  = 5'd13,
        PH_VAL      = 5'd14,
        PH_VEND     = 5'd15,
        PH_LINE     = 5'd16,
        PH_BLANKLF  = 5'd17,
        PH_PAYFIRST = 5'd18,
        PH_PAY      = 5'd19
    } t_phase;

    typedef enum logic [ClassW-1:0] {
        CLS_DELIM  = 3'd0,
        CLS_METHOD = 3'd1,
        CLS_URL    = 3'd2,
        CLS_KEY    = 3'd3,
        CLS_VALUE  = 3'd4,
        CLS_PAY    = 3'd5
    } t_class;

    typedef struct packed {
        logic [ByteW-1:0]    out_byte;
        t_class              field_class;
        logic                field_start;
        logic [VersionW-1:0] version_code;
        logic                parse_error;
        logic                head_done;
        logic                message_ok;
        logic                end_of_message;
    } t_result;

    function automatic logic [ByteW-1:0] to_lower(input logic [ByteW-1:0] b);
        if (b >= ChUpA && b <= ChUpZ) begin
            return b + 8'd32;
        end
        return b;
    endfunction

    // Letters of "get", indexed by match count.
    function automatic logic [ByteW-1:0] get_char(input logic [1:0] idx);
        logic [ByteW-1:0] c;
        case (idx)
            2'd0:    c = 8'h67;
            2'd1:    c = 8'h65;
            2'd2:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/hrp_core.sv =====
// Parser phase registers and the per-byte next-state and tagging logic.
module hrp_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic [hrp_pkg::ByteW-1:0] i_byte,
    input  logic                     i_last,
    output hrp_pkg::t_result         o_result
);
    import hrp_pkg::*;

    t_phase              r_phase, n_phase;
    logic [1:0]          r_cnt, n_cnt;
    logic                r_mis, n_mis;
    logic [1:0]          r_major, n_major;
    logic [VersionW-1:0] r_ver, n_ver;
    logic                r_err, n_err;

    logic   crlf;
    logic   err_set;
    logic   head;
    logic   err_out;
    t_class cls;
    logic   start;

    always_comb begin
        crlf    = (i_byte == ChCr) || (i_byte == ChLf);
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_mis   = r_mis;
        n_major = r_major;
        n_ver   = r_ver;
        err_set = 1'b0;
        cls     = CLS_DELIM;
        start   = 1'b0;
        if (!r_err) begin
            case (r_phase)
                PH_METHOD: begin
                    if (i_byte == ChSp) begin
                        if (r_mis || r_cnt != MethodLen) err_set = 1'b1;
                        else n_phase = PH_SP1;
                    end else if (crlf) begin
                        err_set = 1'b1;
                    end else begin
                        cls   = CLS_METHOD;
                        start = (r_cnt == 2'd0) && !r_mis;
                        if (!r_mis) begin
                            if (r_cnt < MethodLen && to_lower(i_byte) == get_char(r_cnt))
                                n_cnt = r_cnt + 2'd1;
                            else
                                n_mis = 1'b1;
                        end
                    end
                end
                PH_SP1: begin
                    if (i_byte == ChSp) begin
                        n_phase = PH_SP1;
                    end else if (crlf) begin
                        err_set = 1'b1;
                    end else begin
                        cls = CLS_URL; start = 1'b1; n_phase = PH_URL;
                    end
                end
                PH_URL: begin
                    if (i_byte == ChSp) n_phase = PH_SP2;
                    else if (crlf) err_set = 1'b1;
                    else cls = CLS_URL;
                end
                PH_SP2: begin
                    if (i_byte == ChSp) n_phase = PH_SP2;
                    else if (crlf) err_set = 1'b1;
                    else if (i_byte == ChSlash) n_phase = PH_MAJOR;
                    else n_phase = PH_PROTO;
                end
                PH_PROTO: begin
                    if (i_byte == ChSlash) n_phase = PH_MAJOR;
                    else if (crlf) err_set = 1'b1;
                end
                PH_MAJOR: begin
                    if (i_byte == ChOne) n_major = MajorOne;
                    else if (i_byte == ChTwo) n_major = MajorTwo;
                    else err_set = 1'b1;
                    n_phase = PH_DOT;
                end
                PH_DOT: n_phase = PH_MINOR;
                PH_MINOR: begin
                    if (r_major == MajorOne && i_byte == ChZero) n_ver = Ver10;
                    else if (r_major == MajorOne && i_byte == ChOne) n_ver = Ver11;
                    else if (r_major == MajorTwo && i_byte == ChZero) n_ver = Ver20;
                    else err_set = 1'b1;
                    n_phase = PH_EOL;
                end
                PH_EOL: begin
                    if (i_byte == ChLf) n_phase = PH_KEYFIRST;
                end
                PH_KEYFIRST: begin
                    if (crlf) begin
                        err_set = 1'b1;
                    end else if (i_byte == ChColon) begin
                        n_phase = PH_COLSKIP;
                    end else begin
                        cls = CLS_KEY; start = 1'b1; n_phase = PH_KEY;
                    end
                end
                PH_KEY: begin
                    if (i_byte == ChColon) n_phase = PH_COLSKIP;
                    else if (crlf) err_set = 1'b1;
                    else cls = CLS_KEY;
                end
                PH_COLSKIP: n_phase = PH_VSPFIRST;
                PH_VSPFIRST: begin
                    if (i_byte == ChSp) begin
                        n_phase = PH_VSPMORE;
                    end else if (i_byte == ChCr) begin
                        n_phase = PH_VEND;
                    end else begin
                        cls = CLS_VALUE; start = 1'b1; n_phase = PH_VAL;
                    end
                end
                PH_VSPMORE: begin
                    if (i_byte == ChSp) begin
                        n_phase = PH_VSPMORE;
                    end else if (crlf) begin
                        err_set = 1'b1;
                    end else begin
                        cls = CLS_VALUE; start = 1'b1; n_phase = PH_VAL;
                    end
                end
                PH_VAL: begin
                    if (i_byte == ChCr) n_phase = PH_VEND;
                    else if (i_byte == ChLf) err_set = 1'b1;
                    else cls = CLS_VALUE;
                end
                PH_VEND: n_phase = PH_LINE;
                PH_LINE: begin
                    if (i_byte == ChCr) begin
                        n_phase = PH_BLANKLF;
                    end else if (i_byte == ChColon) begin
                        n_phase = PH_COLSKIP;
                    end else begin
                        cls = CLS_KEY; start = 1'b1; n_phase = PH_KEY;
                    end
                end
                PH_BLANKLF: begin
                    if (i_byte == ChLf) n_phase = PH_PAYFIRST;
                    else err_set = 1'b1;
                end
                PH_PAYFIRST: begin
                    cls = CLS_PAY; start = 1'b1; n_phase = PH_PAY;
                end
                PH_PAY: cls = CLS_PAY;
                default: err_set = 1'b1;
            endcase
            if (err_set) begin
                cls   = CLS_DELIM;
                start = 1'b0;
            end
        end
        n_err   = r_err | err_set;
        head    = (n_phase == PH_PAYFIRST) || (n_phase == PH_PAY);
        err_out = n_err | (i_last & ~head);

        o_result.out_byte       = i_byte;
        o_result.field_class    = cls;
        o_result.field_start    = start;
        o_result.version_code   = n_ver;
        o_result.parse_error    = err_out;
        o_result.head_done      = head;
        o_result.message_ok     = i_last & ~err_out & head;
        o_result.end_of_message = i_last;
    end

    // State returns to reset after the last byte of a message.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase <= PH_METHOD;
            r_cnt   <= 2'd0;
            r_mis   <= 1'b0;
            r_major <= MajorNone;
            r_ver   <= VerUnknown;
            r_err   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_mis   <= n_mis;
            r_major <= n_major;
            r_ver   <= n_ver;
            r_err   <= n_err;
        end
    end

endmodule

// ===== rtl/http_request_head_parser.sv =====
// Top level of the HTTP request head parser: input register, parser core, result register.
// Usage
//   Input stream (s_axis): one request byte per item in tdata[7:0], tlast on
//   the final byte of the message. Output stream (m_axis): one item per input
//   byte carrying the echoed byte, its field tag (tuser), the version code,
//   the sticky error, head-done and message-ok flags; tlast copies the input
//   tlast.
// Pipeline
//   An accepted byte is parsed on its way from the input register into the
//   result register and is then offered on m_axis.
// Throughput
//   One item per cycle while m_axis is not stalled, with both register
//   stages moving in the same cycle.
// Stall behavior
//   When i_m_axis_tready is low, the result register holds and the input
//   register can still take one more byte; after that s_axis tready drops.
//   The parser state advances only when a byte moves into the result register.
// Reset
//   i_rst_n (synchronous, active low) empties both stages and puts the parser
//   back in the method phase with the version unknown. The parser also returns
//   to that state on its own after each byte that carries tlast.
module http_request_head_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [hrp_pkg::InDataW-1:0]   i_s_axis_tdata,  // [7:0] data_byte
    input  logic                          i_s_axis_tlast,  // last
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [7:0] out_byte, [9:8] version_code, [10] parse_error, [11] head_done,
    // [12] message_ok, [15:13] zero
    output logic [hrp_pkg::OutDataW-1:0]  o_m_axis_tdata,
    output logic [hrp_pkg::OutUserW-1:0]  o_m_axis_tuser,  // [2:0] field_class, [3] field_start
    output logic                          o_m_axis_tlast   // end_of_message
);
    import hrp_pkg::*;

    // input stage
    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_in_last;

    // result stage
    logic    r_out_valid;
    t_result r_out;

    logic    adv;      // byte moves from input stage into result stage
    t_result core_res;

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata[ByteW-1:0];
            r_in_last <= i_s_axis_tlast;
        end
    end

    hrp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out.message_ok, r_out.head_done,
                              r_out.parse_error, r_out.version_code, r_out.out_byte};
    assign o_m_axis_tuser  = {r_out.field_start, r_out.field_class};
    assign o_m_axis_tlast  = r_out.end_of_message;

    // A good message needs a finished head, no error, and sits on the last byte.
    a_ok_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out.message_ok) |->
            (r_out.head_done && !r_out.parse_error && r_out.end_of_message))
        else $error("message_ok without finished head");

    // Field starts only tag real field bytes.
    a_start_tagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out.field_start) |-> (r_out.field_class != CLS_DELIM))
        else $error("field_start on delimiter byte");

    // Input side backs up only when the input stage holds an item that cannot move.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_out_valid && !i_m_axis_tready))
        else $error("input stalled without a blocked output");

endmodule

// ===== tb/http_request_head_parser_tb.sv =====
// Testbench for http_request_head_parser: directed and random requests checked against a byte predictor.
`timescale 1ns / 1ps

module http_request_head_parser_tb;
    import hrp_pkg::*;

    localparam int        ByteTarget = 1800;        // random bytes to send
    localparam int        DrainEvery = 450;         // drain when bytes queued is one short of a multiple
    localparam int        IdlePct    = 16;          // idle / stall percentage
    localparam int        QuietLo    = 700;         // byte window with no idling
    localparam int        QuietHi    = 1000;
    localparam logic [23:0] WordGet  = "get";

    // One queued byte of a request; wait_drain marks a pause until the pipe is empty.
    typedef struct {
        logic [ByteW-1:0] data;
        logic             last;
        bit               wait_drain;
    } t_req_byte;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic [OutUserW-1:0] m_tuser;
    logic                m_tlast;

    t_req_byte        pending_bytes[$];
    t_result          predicted_results[$];
    logic [ByteW-1:0] req_bytes[$];     // request under construction

    // Predictor state, follows the parser one accepted byte at a time.
    t_phase           rq_phase;
    logic [1:0]       get_count;
    logic             get_bad;
    logic [1:0]       ver_major;
    logic [VersionW-1:0] ver_code;
    logic             sticky_err;

    int bytes_queued;
    int bytes_sent;
    int results_seen;
    int messages_seen;
    int messages_ok;
    int mismatches;

    always #10 clk = ~clk;

    http_request_head_parser i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),     // [7:0] data_byte
        .i_s_axis_tlast  (s_tlast),     // last
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),     // [7:0] byte, [9:8] version, [10] error, [11] head, [12] ok
        .o_m_axis_tuser  (m_tuser),     // [2:0] field_class, [3] field_start
        .o_m_axis_tlast  (m_tlast)      // end_of_message
    );

    function automatic void clear_parse_state();
        rq_phase   = PH_METHOD;
        get_count  = 2'd0;
        get_bad    = 1'b0;
        ver_major  = MajorNone;
        ver_code   = VerUnknown;
        sticky_err = 1'b0;
    endfunction

    // Advance the predicted parser by one byte and return the tagged result.
    function automatic t_result parse_byte(input logic [ByteW-1:0] b, input logic lst);
        t_result          r;
        t_class           cls;
        logic             st;
        logic             crlf;
        logic             head;
        logic [ByteW-1:0] lc;
        cls  = CLS_DELIM;
        st   = 1'b0;
        crlf = (b == ChCr) || (b == ChLf);
        if (!sticky_err) begin
            case (rq_phase)
                PH_METHOD: begin
                    if (b == ChSp) begin
                        if (get_bad || get_count != MethodLen) sticky_err = 1'b1;
                        else rq_phase = PH_SP1;
                    end else if (crlf) begin
                        sticky_err = 1'b1;
                    end else begin
                        cls = CLS_METHOD;
                        st  = (get_count == 2'd0) && !get_bad;
                        if (!get_bad) begin
                            lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                            if (get_count < MethodLen && lc == WordGet[23 - 8*get_count -: 8])
                                get_count = get_count + 2'd1;
                            else
                                get_bad = 1'b1;
                        end
                    end
                end
                PH_SP1: begin
                    if (crlf) sticky_err = 1'b1;
                    else if (b != ChSp) begin
                        cls = CLS_URL; st = 1'b1; rq_phase = PH_URL;
                    end
                end
                PH_URL: begin
                    if (b == ChSp) rq_phase = PH_SP2;
                    else if (crlf) sticky_err = 1'b1;
                    else cls = CLS_URL;
                end
                PH_SP2: begin
                    if (crlf) sticky_err = 1'b1;
                    else if (b == ChSlash) rq_phase = PH_MAJOR;
                    else if (b != ChSp) rq_phase = PH_PROTO;
                end
                PH_PROTO: begin
                    if (b == ChSlash) rq_phase = PH_MAJOR;
                    else if (crlf) sticky_err = 1'b1;
                end
                PH_MAJOR: begin
                    if (b == ChOne) ver_major = MajorOne;
                    else if (b == ChTwo) ver_major = MajorTwo;
                    else sticky_err = 1'b1;
                    rq_phase = PH_DOT;
                end
                PH_DOT: rq_phase = PH_MINOR;
                PH_MINOR: begin
                    if (ver_major == MajorOne && b == ChZero) ver_code = Ver10;
                    else if (ver_major == MajorOne && b == ChOne) ver_code = Ver11;
                    else if (ver_major == MajorTwo && b == ChZero) ver_code = Ver20;
                    else sticky_err = 1'b1;
                    rq_phase = PH_EOL;
                end
                PH_EOL: if (b == ChLf) rq_phase = PH_KEYFIRST;
                PH_KEYFIRST: begin
                    if (crlf) sticky_err = 1'b1;
                    else if (b == ChColon) rq_phase = PH_COLSKIP;
                    else begin
                        cls = CLS_KEY; st = 1'b1; rq_phase = PH_KEY;
                    end
                end
                PH_KEY: begin
                    if (b == ChColon) rq_phase = PH_COLSKIP;
                    else if (crlf) sticky_err = 1'b1;
                    else cls = CLS_KEY;
                end
                PH_COLSKIP: rq_phase = PH_VSPFIRST;
                PH_VSPFIRST: begin
                    if (b == ChSp) rq_phase = PH_VSPMORE;
                    else if (b == ChCr) rq_phase = PH_VEND;
                    else begin
                        cls = CLS_VALUE; st = 1'b1; rq_phase = PH_VAL;
                    end
                end
                PH_VSPMORE: begin
                    if (crlf) sticky_err = 1'b1;
                    else if (b != ChSp) begin
                        cls = CLS_VALUE; st = 1'b1; rq_phase = PH_VAL;
                    end
                end
                PH_VAL: begin
                    if (b == ChCr) rq_phase = PH_VEND;
                    else if (b == ChLf) sticky_err = 1'b1;
                    else cls = CLS_VALUE;
                end
                PH_VEND: rq_phase = PH_LINE;
                PH_LINE: begin
                    if (b == ChCr) rq_phase = PH_BLANKLF;
                    else if (b == ChColon) rq_phase = PH_COLSKIP;
                    else begin
                        cls = CLS_KEY; st = 1'b1; rq_phase = PH_KEY;
                    end
                end
                PH_BLANKLF: begin
                    if (b == ChLf) rq_phase = PH_PAYFIRST;
                    else sticky_err = 1'b1;
                end
                PH_PAYFIRST: begin
                    cls = CLS_PAY; st = 1'b1; rq_phase = PH_PAY;
                end
                PH_PAY: cls = CLS_PAY;
                default: sticky_err = 1'b1;
            endcase
            // the byte that raises an error is tagged as delimiter
            if (sticky_err) begin
                cls = CLS_DELIM;
                st  = 1'b0;
            end
        end
        head = (rq_phase == PH_PAYFIRST) || (rq_phase == PH_PAY);
        if (lst && !head) sticky_err = 1'b1;     // message ended before the blank line
        r.out_byte       = b;
        r.field_class    = cls;
        r.field_start    = st;
        r.version_code   = ver_code;
        r.parse_error    = sticky_err;
        r.head_done      = head;
        r.message_ok     = lst && !sticky_err && head;
        r.end_of_message = lst;
        if (lst) clear_parse_state();
        return r;
    endfunction

    // ---- request construction ------------------------------------------------

    function automatic logic [ByteW-1:0] rand_byte();
        return ByteW'($urandom_range(255));
    endfunction

    function automatic logic [ByteW-1:0] rand_digit();
        return ChZero + ByteW'($urandom_range(9));
    endfunction

    // Any byte that is not a space, CR, LF or colon.
    function automatic logic [ByteW-1:0] plain_byte();
        logic [ByteW-1:0] b;
        do begin
            b = rand_byte();
        end while (b == ChSp || b == ChCr || b == ChLf || b == ChColon);
        return b;
    endfunction

    // Append one byte to the request under construction.
    function automatic void add_byte(input logic [ByteW-1:0] b);
        req_bytes.insert(req_bytes.size(), b);
    endfunction

    function automatic void add_text(input string s);
        foreach (s[i]) add_byte(s[i]);
    endfunction

    function automatic void add_crlf();
        add_byte(ChCr);
        add_byte(ChLf);
    endfunction

    // Move the built request into the send queue, last mark on its final byte.
    function automatic void queue_request();
        t_req_byte it;
        foreach (req_bytes[i]) begin
            it.data       = req_bytes[i];
            it.last       = (i == req_bytes.size() - 1);
            it.wait_drain = 1'b0;
            pending_bytes.insert(pending_bytes.size(), it);
        end
        bytes_queued += req_bytes.size();
        req_bytes.delete();
    endfunction

    function automatic void queue_drain();
        t_req_byte it;
        it.data       = '0;
        it.last       = 1'b0;
        it.wait_drain = 1'b1;
        pending_bytes.insert(pending_bytes.size(), it);
    endfunction

    // Mostly well-formed requests with random content; some are damaged or noise.
    function automatic void build_request();
        logic [ByteW-1:0] c;
        int               k;
        int               n_hdr;
        int               n_sp;
        k = $urandom_range(99);
        if (k < 6) begin
            repeat ($urandom_range(1, 8)) add_byte(rand_byte());
            return;
        end
        for (int i = 0; i < 3; i++) begin
            c = WordGet[23 - 8*i -: 8];
            if ($urandom_range(1)) c = c - 8'd32;
            add_byte(c);
        end
        case ($urandom_range(19))
            0: req_bytes[$urandom_range(2)] = plain_byte();
            1: req_bytes.delete($urandom_range(2));
            2: add_byte(plain_byte());
            3: req_bytes.delete();
            default: ;
        endcase
        repeat ($urandom_range(1, 2)) add_byte(ChSp);
        add_byte(ChSlash);
        repeat ($urandom_range(0, 4)) add_byte(plain_byte());
        repeat ($urandom_range(1, 2)) add_byte(ChSp);
        if ($urandom_range(3) != 0) add_text("HTTP");
        add_byte(ChSlash);
        case ($urandom_range(9))
            0, 1, 2: add_text("1.0");
            3, 4, 5: add_text("1.1");
            6, 7, 8: add_text("2.0");
            default: begin
                add_byte(rand_digit());
                add_byte(rand_byte());
                add_byte(rand_digit());
            end
        endcase
        case ($urandom_range(9))
            0, 1: add_byte(ChLf);
            2: begin
                add_byte(rand_byte());
                add_crlf();
            end
            default: add_crlf();
        endcase
        n_hdr = $urandom_range(1, 3);
        for (int h = 0; h < n_hdr; h++) begin
            // a later header line may start its key with LF
            if (h > 0 && $urandom_range(15) == 0) add_byte(ChLf);
            repeat ($urandom_range(0, 4)) add_byte(plain_byte());
            add_byte(ChColon);
            add_byte(($urandom_range(7) == 0) ? rand_byte() : ChSp);
            n_sp = $urandom_range(0, 2);
            repeat (n_sp) add_byte(ChSp);
            if (n_sp == 0 && $urandom_range(9) == 0) add_byte(ChLf);
            repeat ($urandom_range(0, 4)) add_byte(plain_byte());
            add_byte(ChCr);
            add_byte(($urandom_range(7) == 0) ? rand_byte() : ChLf);
        end
        add_crlf();
        repeat ($urandom_range(0, 5)) add_byte(rand_byte());
        // damage: a stray CR / LF / random byte, or an early end
        if (k < 18) begin
            case ($urandom_range(2))
                0: req_bytes[$urandom_range(req_bytes.size() - 1)] = ChCr;
                1: req_bytes[$urandom_range(req_bytes.size() - 1)] = ChLf;
                default: req_bytes[$urandom_range(req_bytes.size() - 1)] = rand_byte();
            endcase
        end else if (k < 26) begin
            k = $urandom_range(1, req_bytes.size() - 1);
            while (req_bytes.size() > k) void'(req_bytes.pop_back());
        end
    endfunction

    // ---- driver: feeds s_axis from pending_bytes ------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted_results.insert(predicted_results.size(),
                                         parse_byte(s_tdata, s_tlast));
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() != 0 && pending_bytes[0].wait_drain) begin
                    // hold off until every predicted result has come out
                    s_tvalid <= 1'b0;
                    if (predicted_results.size() == 0) void'(pending_bytes.pop_front());
                end else if (pending_bytes.size() != 0 &&
                             (($urandom_range(99) >= IdlePct) ||
                              (bytes_sent >= QuietLo && bytes_sent < QuietHi))) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_bytes[0].data;
                    s_tlast  <= pending_bytes[0].last;
                    void'(pending_bytes.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---- monitor: checks m_axis against the oldest prediction -----------------
    function automatic void check_field(input string name, input int exp, input int act);
        if (exp != act) begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        t_result exp;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    $error("result with no prediction waiting: tdata %h tuser %h",
                           m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    exp = predicted_results.pop_front();
                    check_field("out_byte",       exp.out_byte,       m_tdata[7:0]);
                    check_field("version_code",   exp.version_code,   m_tdata[9:8]);
                    check_field("parse_error",    exp.parse_error,    m_tdata[10]);
                    check_field("head_done",      exp.head_done,      m_tdata[11]);
                    check_field("message_ok",     exp.message_ok,     m_tdata[12]);
                    check_field("tdata_pad",      0,                  m_tdata[15:13]);
                    check_field("field_class",    exp.field_class,    m_tuser[2:0]);
                    check_field("field_start",    exp.field_start,    m_tuser[3]);
                    check_field("end_of_message", exp.end_of_message, m_tlast);
                end
                results_seen++;
                if (m_tlast) begin
                    messages_seen++;
                    if (m_tdata[12]) messages_ok++;
                end
            end
            m_tready <= ($urandom_range(99) >= IdlePct) ||
                        (results_seen >= QuietLo && results_seen < QuietHi);
        end
    end

    // ---- stimulus and end of run ----------------------------------------------
    initial begin
        clear_parse_state();
        bytes_queued  = 0;
        bytes_sent    = 0;
        results_seen  = 0;
        messages_seen = 0;
        messages_ok   = 0;
        mismatches    = 0;

        // shortest valid request: empty key and value, version 1.0, no payload
        add_text("GET / /1.0");
        add_byte(ChLf);
        add_byte(ChColon);
        add_byte(ChSp);
        add_crlf();
        add_crlf();
        queue_request();
        // stray CR as the only byte
        add_byte(ChCr);
        queue_request();
        // top byte value as method data, then early end
        add_byte(8'hFF);
        queue_request();
        queue_drain();

        bytes_queued = 0;
        while (bytes_queued < ByteTarget) begin
            build_request();
            queue_request();
            if (bytes_queued / DrainEvery != (bytes_queued + 1) / DrainEvery ||
                $urandom_range(49) == 0)
                queue_drain();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk);
        while (predicted_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes in %0d requests; %0d requests parsed as valid.",
                 bytes_sent, messages_seen, messages_ok);
        $display("Covered stray CR/LF, bad methods and versions, truncation and noise.");
        if (mismatches == 0 && predicted_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d predictions still waiting", predicted_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== http_request_head_parser.f =====
rtl/hrp_pkg.sv
rtl/hrp_core.sv
rtl/http_request_head_parser.sv
tb/http_request_head_parser_tb.sv
